FILE: sv/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Types and codes shared by the sorted value table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

  localparam int ValueWidth  = 32;
  localparam int ResultLimit = 32;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_SEARCH = 2'd2,
    FN_DUMP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD
  } state_t;

  typedef struct packed {
    func_t                  func;
    logic signed [31:0]     value;
  } svt_in_t;

  typedef struct packed {
    status_t                status;
    logic [4:0]             position;
    logic signed [31:0]     entry_value;
    logic [5:0]             entry_count;
    logic                   last;
  } svt_out_t;

  typedef struct packed {
    logic inc;
    logic dec;
  } cnt_upd_t;

endpackage

`default_nettype wire

FILE: sv/sorted_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_value_table_core
// Bounded table of signed 32-bit values kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
// Command channel: cmd (func, value) is taken on a clock edge with start high
// and busy low. Insert places the value after equal entries, delete removes
// the first equal entry, search reports the first equal entry, dump lists
// the entries in order (at most 32 results, the final one marked last).
// Results: one item per cycle on result while result_valid is high; the
// receiver must take it in that cycle, there is no backpressure.
// Operation: all entries sit in a single RAM with a registered read; operations
// stream one entry per cycle through its read port and write shifted data
// behind the read pointer. With n stored entries:
//   insert into an empty or full table, and delete, search or dump on an
//   empty table: result in the next cycle, busy stays low.
//   insert: the scan runs from the top down to the slot.
//   delete reads all n entries, search at most n, dump min(n,32).
// busy is high for the scan; the final result appears in the cycle where
// busy has dropped, so a new command may be issued there.
// Reset clears the entry count; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_value_table_core #(
  parameter int CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire svt_pkg::svt_in_t   cmd,
  output logic                    result_valid,
  output svt_pkg::svt_out_t       result
);

  import svt_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  logic [CW-1:0] count;
  cnt_upd_t      upd;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd.inc) begin
      count <= count + 1'b1;
    end else if (upd.dec) begin
      count <= count - 1'b1;
    end
  end

  svt_ram #(
    .WIDTH(ValueWidth),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  svt_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .count        (count),
    .upd          (upd),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: sv/svt_ram.sv
// ----------------------------------------------------------------------------
// svt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/svt_seq.sv
// ----------------------------------------------------------------------------
// svt_seq
// Operation sequencer: streams table entries out of the RAM one per cycle,
// compares, shifts entries up or down by writing behind the read pointer,
// and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_seq #(
  parameter int CAPACITY = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire svt_pkg::svt_in_t                cmd,
  input  wire logic [$clog2(CAPACITY+1)-1:0]   count,
  output svt_pkg::cnt_upd_t                    upd,
  output logic                                 ram_we,
  output logic [$clog2(CAPACITY)-1:0]          ram_waddr,
  output logic [31:0]                          ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]          ram_raddr,
  input  wire logic [31:0]                     ram_rdata,
  output logic                                 result_valid,
  output svt_pkg::svt_out_t                    result
);

  import svt_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  state_t             state, state_next;
  func_t              op, op_next;
  logic signed [31:0] val, val_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [IW-1:0]      idx, idx_next;
  logic [IW-1:0]      lim, lim_next;
  logic               issuing, issuing_next;
  logic               rd_vld, rd_vld_next;
  logic [IW-1:0]      rd_idx, rd_idx_next;
  logic               found, found_next;
  logic [IW-1:0]      hit_pos, hit_pos_next;
  logic               res_vld, res_vld_next;
  svt_out_t           res, res_next;

  logic signed [31:0] d;
  logic               hit;
  logic [31:0]        dump_lim;

  function automatic svt_out_t mk_res(status_t st, logic [31:0] pos, logic [31:0] v,
                                      logic [31:0] c, logic lst);
    svt_out_t r;
    r.status      = st;
    r.position    = pos[4:0];
    r.entry_value = v;
    r.entry_count = c[5:0];
    r.last        = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_vld  <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= rd_vld_next;
      res_vld <= res_vld_next;
    end
    op      <= op_next;
    val     <= val_next;
    cnt     <= cnt_next;
    idx     <= idx_next;
    lim     <= lim_next;
    issuing <= issuing_next;
    rd_idx  <= rd_idx_next;
    found   <= found_next;
    hit_pos <= hit_pos_next;
    res     <= res_next;
  end

  always_comb begin
    d        = $signed(ram_rdata);
    hit      = (d == val);
    dump_lim = (32'(count) > 32'(ResultLimit)) ? 32'(ResultLimit - 1) : 32'(count) - 32'd1;

    state_next   = state;
    op_next      = op;
    val_next     = val;
    cnt_next     = cnt;
    idx_next     = idx;
    lim_next     = lim;
    issuing_next = issuing;
    rd_vld_next  = 1'b0;
    rd_idx_next  = idx;
    found_next   = found;
    hit_pos_next = hit_pos;
    res_vld_next = 1'b0;
    res_next     = res;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = val;
    ram_raddr    = idx;
    upd          = '0;
    busy         = 1'b1;

    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op_next      = cmd.func;
          val_next     = cmd.value;
          cnt_next     = count;
          found_next   = 1'b0;
          hit_pos_next = '0;
          issuing_next = 1'b1;
          idx_next     = '0;
          lim_next     = IW'(32'(count) - 32'd1);
          case (cmd.func)
            FN_INSERT: begin
              if (32'(count) >= 32'(CAPACITY)) begin
                res_vld_next = 1'b1;
                res_next = mk_res(ST_FULL, '0, cmd.value, 32'(count), 1'b1);
              end else if (count == '0) begin
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = cmd.value;
                upd.inc      = 1'b1;
                res_vld_next = 1'b1;
                res_next = mk_res(ST_OK, '0, cmd.value, 32'd1, 1'b1);
              end else begin
                idx_next   = IW'(32'(count) - 32'd1);
                state_next = S_SCAN;
              end
            end
            FN_DELETE, FN_SEARCH: begin
              if (count == '0) begin
                res_vld_next = 1'b1;
                res_next = mk_res(ST_NOT_FOUND, '0, cmd.value, '0, 1'b1);
              end else begin
                state_next = S_SCAN;
              end
            end
            FN_DUMP: begin
              if (count == '0) begin
                res_vld_next = 1'b1;
                res_next = mk_res(ST_EMPTY, '0, '0, '0, 1'b1);
              end else begin
                lim_next   = IW'(dump_lim);
                state_next = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (issuing) begin
          rd_vld_next = 1'b1;
          rd_idx_next = idx;
          if (op == FN_INSERT) begin
            if (idx == '0) issuing_next = 1'b0;
            else idx_next = idx - 1'b1;
          end else begin
            if (idx == lim) issuing_next = 1'b0;
            else idx_next = idx + 1'b1;
          end
        end
        if (rd_vld) begin
          case (op)
            FN_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = rd_idx + 1'b1;
              if (d > val) begin
                ram_wdata = d;
                if (rd_idx == '0) state_next = S_HEAD;
              end else begin
                ram_wdata    = val;
                upd.inc      = 1'b1;
                res_vld_next = 1'b1;
                res_next = mk_res(ST_OK, 32'(rd_idx) + 32'd1, val, 32'(cnt) + 32'd1, 1'b1);
                state_next = S_IDLE;
              end
            end
            FN_DELETE: begin
              if (found) begin
                ram_we    = 1'b1;
                ram_waddr = rd_idx - 1'b1;
                ram_wdata = d;
              end else if (hit) begin
                found_next   = 1'b1;
                hit_pos_next = rd_idx;
              end
              if (rd_idx == lim) begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                if (found || hit) begin
                  upd.dec  = 1'b1;
                  res_next = mk_res(ST_OK, found ? 32'(hit_pos) : 32'(rd_idx), val,
                                    32'(cnt) - 32'd1, 1'b1);
                end else begin
                  res_next = mk_res(ST_NOT_FOUND, '0, val, 32'(cnt), 1'b1);
                end
              end
            end
            FN_SEARCH: begin
              if (hit) begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                res_next = mk_res(ST_OK, 32'(rd_idx), d, 32'(cnt), 1'b1);
              end else if (rd_idx == lim) begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                res_next = mk_res(ST_NOT_FOUND, '0, val, 32'(cnt), 1'b1);
              end
            end
            FN_DUMP: begin
              res_vld_next = 1'b1;
              res_next = mk_res(ST_OK, 32'(rd_idx), d, 32'(cnt), rd_idx == lim);
              if (rd_idx == lim) state_next = S_IDLE;
            end
            default: ;
          endcase
        end
      end

      S_HEAD: begin
        ram_we       = 1'b1;
        ram_waddr    = '0;
        ram_wdata    = val;
        upd.inc      = 1'b1;
        res_vld_next = 1'b1;
        res_next     = mk_res(ST_OK, '0, val, 32'(cnt) + 32'd1, 1'b1);
        state_next   = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign result_valid = res_vld;
  assign result       = res;

endmodule

`default_nettype wire

FILE: sv/svt_chk.sv
// ----------------------------------------------------------------------------
// svt_chk
// Port-level checks for sorted_value_table_core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid,
  input wire svt_pkg::svt_out_t result
);

  import svt_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

  a_res_caused: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy || start))
    else $error("result without a command");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy after final result");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("idle before final result");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_EMPTY |-> result.entry_count == 6'd0 && result.last)
    else $error("bad empty dump result");

endmodule

bind sorted_value_table_core svt_chk u_chk (.*);

`default_nettype wire
